[hw/rtl/gflba_pkg.sv]
// Shared constants, codes and types of the grouped free-list block allocator.
`timescale 1ns / 1ps
`default_nettype none
package gflba_pkg;

   localparam int GROUP_SIZE  = 50;
   localparam int NUM_BLOCKS  = 1024;
   localparam int MAX_REQUEST = 16;

   localparam int BLK_W      = 10;                          // block number field
   localparam int CNT_FLD_W  = 5;                           // request count field
   localparam int ELEM_W     = 11;                          // stack / link entry
   localparam int TOTAL_W    = 11;
   localparam int STACK_AW   = $clog2(GROUP_SIZE);
   localparam int GRP_CNT_W  = $clog2(GROUP_SIZE + 1);
   localparam int FILL_W     = $clog2(GROUP_SIZE + 1);
   localparam int REM_W      = $clog2(MAX_REQUEST + 1);
   localparam int LINK_DEPTH = NUM_BLOCKS * GROUP_SIZE;
   localparam int LINK_AW    = $clog2(LINK_DEPTH);

   localparam logic [ELEM_W-1:0]  END_MARK  = {ELEM_W{1'b1}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_SHORT = 2'd1;
   localparam logic [1:0] STATUS_END   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REJECT,
      ST_POP,
      ST_POP_WAIT,
      ST_RELOAD,
      ST_SPILL
   } state_type;

endpackage
`default_nettype wire

[hw/rtl/gflba_ram.sv]
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module gflba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/grouped_free_list_block_allocator.sv]
// Top level of the grouped free-list block allocator: control, cached stack and link store.
// Free item: the freed block is pushed onto the stack, or a full stack spills to the link store under it.
// Allocate item: accepted, then each block is popped from the stack RAM through its registered read;
// the bottom entry is handed out and the stack refilled from its link group; a short or end result closes it.
// One item at a time; an output register lets one result wait while the next block is read.
// Synchronous reset: fill 1, end marker at the bottom, free count 0; link store not cleared.
`timescale 1ns / 1ps
`default_nettype none
module grouped_free_list_block_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [4:0] req_count, [14:5] freed_block, [15] zero
   input  wire logic        req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [9:0] given_block, [11:10] status, [15:12] zero
   output logic             rsp_tlast
);

   // control state
   gflba_pkg::state_type                 state_ff, state_in;
   logic [gflba_pkg::FILL_W-1:0]         fill_ff, fill_in;
   logic [gflba_pkg::TOTAL_W-1:0]        total_ff, total_in;
   logic [gflba_pkg::ELEM_W-1:0]         bottom_ff, bottom_in;
   logic [gflba_pkg::REM_W-1:0]          remain_ff, remain_in;
   logic [gflba_pkg::GRP_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                                 wvalid_ff, wvalid_in;
   logic [gflba_pkg::STACK_AW-1:0]       widx_ff, widx_in;
   logic [gflba_pkg::LINK_AW-1:0]        base_ff, base_in;
   logic [gflba_pkg::BLK_W-1:0]          blk_ff, blk_in;
   logic                                 stale_ff, stale_in;

   // output register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [gflba_pkg::BLK_W-1:0]          rsp_blk_ff, rsp_blk_in;
   logic [1:0]                           rsp_status_ff, rsp_status_in;
   logic                                 rsp_last_ff, rsp_last_in;

   // memory ports
   logic                                 stk_we, stk_re;
   logic [gflba_pkg::STACK_AW-1:0]       stk_wa, stk_ra;
   logic [gflba_pkg::ELEM_W-1:0]         stk_wd, stk_rd;
   logic                                 lnk_we, lnk_re;
   logic [gflba_pkg::LINK_AW-1:0]        lnk_wa, lnk_ra;
   logic [gflba_pkg::ELEM_W-1:0]         lnk_wd, lnk_rd;

   // request fields
   logic                                 in_func;
   logic [gflba_pkg::CNT_FLD_W-1:0]      in_count;
   logic [gflba_pkg::BLK_W-1:0]          in_blk;
   logic [gflba_pkg::REM_W-1:0]          clamp_count;
   logic                                 out_free;
   logic                                 group_done;

   assign in_func  = req_tuser;
   assign in_count = req_tdata[gflba_pkg::CNT_FLD_W-1:0];
   assign in_blk   = req_tdata[gflba_pkg::CNT_FLD_W +: gflba_pkg::BLK_W];

   always_comb begin
      if (int'(in_count) > gflba_pkg::MAX_REQUEST) begin
         clamp_count = gflba_pkg::REM_W'(gflba_pkg::MAX_REQUEST);
      end else begin
         clamp_count = gflba_pkg::REM_W'(in_count);
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign group_done = wvalid_ff && (int'(widx_ff) == gflba_pkg::GROUP_SIZE - 1);
   assign req_tready = (state_ff == gflba_pkg::ST_IDLE);

   gflba_ram #(
      .WIDTH (gflba_pkg::ELEM_W),
      .DEPTH (gflba_pkg::GROUP_SIZE)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_en   (stk_re),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   gflba_ram #(
      .WIDTH (gflba_pkg::ELEM_W),
      .DEPTH (gflba_pkg::LINK_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (lnk_we),
      .wr_addr (lnk_wa),
      .wr_data (lnk_wd),
      .rd_en   (lnk_re),
      .rd_addr (lnk_ra),
      .rd_data (lnk_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gflba_pkg::ST_IDLE;
         fill_ff      <= gflba_pkg::FILL_W'(1);
         total_ff     <= '0;
         bottom_ff    <= gflba_pkg::END_MARK;
         remain_ff    <= '0;
         cnt_ff       <= '0;
         wvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         bottom_ff    <= bottom_in;
         remain_ff    <= remain_in;
         cnt_ff       <= cnt_in;
         wvalid_ff    <= wvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      widx_ff       <= widx_in;
      base_ff       <= base_in;
      blk_ff        <= blk_in;
      stale_ff      <= stale_in;
      rsp_blk_ff    <= rsp_blk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      total_in      = total_ff;
      bottom_in     = bottom_ff;
      remain_in     = remain_ff;
      cnt_in        = cnt_ff;
      wvalid_in     = 1'b0;
      widx_in       = cnt_ff[gflba_pkg::STACK_AW-1:0];
      base_in       = base_ff;
      blk_in        = blk_ff;
      stale_in      = stale_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_blk_in    = rsp_blk_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      stk_we        = 1'b0;
      stk_wa        = fill_ff[gflba_pkg::STACK_AW-1:0];
      stk_wd        = gflba_pkg::ELEM_W'(in_blk);
      stk_re        = 1'b0;
      stk_ra        = gflba_pkg::STACK_AW'(fill_ff - gflba_pkg::FILL_W'(1));
      lnk_we        = 1'b0;
      lnk_wa        = base_ff + gflba_pkg::LINK_AW'(widx_ff);
      lnk_wd        = (widx_ff == '0) ? bottom_ff : stk_rd;
      lnk_re        = 1'b0;
      lnk_ra        = base_ff + gflba_pkg::LINK_AW'(cnt_ff);

      case (state_ff)
         gflba_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (in_func == gflba_pkg::FUNC_FREE) begin
                  if (int'(in_blk) < gflba_pkg::NUM_BLOCKS) begin
                     if (total_ff != gflba_pkg::TOTAL_MAX) begin
                        total_in = total_ff + gflba_pkg::TOTAL_W'(1);
                     end
                     if (int'(fill_ff) >= gflba_pkg::GROUP_SIZE) begin
                        // full stack goes out to the link store under the freed block
                        base_in  = gflba_pkg::LINK_AW'(in_blk)
                                   * gflba_pkg::LINK_AW'(gflba_pkg::GROUP_SIZE);
                        blk_in   = in_blk;
                        cnt_in   = '0;
                        state_in = gflba_pkg::ST_SPILL;
                     end else begin
                        stk_we  = 1'b1;
                        fill_in = fill_ff + gflba_pkg::FILL_W'(1);
                     end
                  end
               end else if (clamp_count != '0) begin
                  remain_in = clamp_count;
                  if (total_ff < gflba_pkg::TOTAL_W'(clamp_count)) begin
                     state_in = gflba_pkg::ST_REJECT;
                  end else begin
                     state_in = gflba_pkg::ST_POP;
                  end
               end
            end
         end

         gflba_pkg::ST_REJECT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_blk_in    = '0;
               rsp_status_in = gflba_pkg::STATUS_SHORT;
               rsp_last_in   = 1'b1;
               state_in      = gflba_pkg::ST_IDLE;
            end
         end

         gflba_pkg::ST_POP: begin
            if (fill_ff > gflba_pkg::FILL_W'(1)) begin
               stk_re   = 1'b1;
               fill_in  = fill_ff - gflba_pkg::FILL_W'(1);
               state_in = gflba_pkg::ST_POP_WAIT;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               if (bottom_ff == gflba_pkg::END_MARK) begin
                  rsp_blk_in    = '0;
                  rsp_status_in = gflba_pkg::STATUS_END;
                  rsp_last_in   = 1'b1;
                  state_in      = gflba_pkg::ST_IDLE;
               end else begin
                  // hand out the group head, then refill the stack from its link group
                  rsp_blk_in    = bottom_ff[gflba_pkg::BLK_W-1:0];
                  rsp_status_in = gflba_pkg::STATUS_OK;
                  rsp_last_in   = (remain_ff == gflba_pkg::REM_W'(1));
                  remain_in     = remain_ff - gflba_pkg::REM_W'(1);
                  if (total_ff != '0) begin
                     total_in = total_ff - gflba_pkg::TOTAL_W'(1);
                  end
                  stale_in = (int'(bottom_ff) >= gflba_pkg::NUM_BLOCKS);
                  base_in  = gflba_pkg::LINK_AW'(bottom_ff[gflba_pkg::BLK_W-1:0])
                             * gflba_pkg::LINK_AW'(gflba_pkg::GROUP_SIZE);
                  cnt_in   = '0;
                  state_in = gflba_pkg::ST_RELOAD;
               end
            end
         end

         gflba_pkg::ST_POP_WAIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_blk_in    = stk_rd[gflba_pkg::BLK_W-1:0];
               rsp_status_in = gflba_pkg::STATUS_OK;
               rsp_last_in   = (remain_ff == gflba_pkg::REM_W'(1));
               remain_in     = remain_ff - gflba_pkg::REM_W'(1);
               if (total_ff != '0) begin
                  total_in = total_ff - gflba_pkg::TOTAL_W'(1);
               end
               if (remain_ff == gflba_pkg::REM_W'(1)) begin
                  state_in = gflba_pkg::ST_IDLE;
               end else begin
                  state_in = gflba_pkg::ST_POP;
               end
            end
         end

         gflba_pkg::ST_RELOAD: begin
            if (int'(cnt_ff) < gflba_pkg::GROUP_SIZE) begin
               lnk_re    = 1'b1;
               wvalid_in = 1'b1;
               cnt_in    = cnt_ff + gflba_pkg::GRP_CNT_W'(1);
            end
            if (wvalid_ff) begin
               stk_we = 1'b1;
               stk_wa = widx_ff;
               stk_wd = stale_ff ? '0 : lnk_rd;
               if (widx_ff == '0) begin
                  bottom_in = stale_ff ? '0 : lnk_rd;
               end
            end
            if (group_done) begin
               fill_in = gflba_pkg::FILL_W'(gflba_pkg::GROUP_SIZE);
               if (remain_ff == '0) begin
                  state_in = gflba_pkg::ST_IDLE;
               end else begin
                  state_in = gflba_pkg::ST_POP;
               end
            end
         end

         gflba_pkg::ST_SPILL: begin
            if (int'(cnt_ff) < gflba_pkg::GROUP_SIZE) begin
               stk_re    = 1'b1;
               stk_ra    = cnt_ff[gflba_pkg::STACK_AW-1:0];
               wvalid_in = 1'b1;
               cnt_in    = cnt_ff + gflba_pkg::GRP_CNT_W'(1);
            end
            lnk_we = wvalid_ff;
            if (group_done) begin
               bottom_in = gflba_pkg::ELEM_W'(blk_ff);
               fill_in   = gflba_pkg::FILL_W'(1);
               state_in  = gflba_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = gflba_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_status_ff, rsp_blk_ff};
   assign rsp_tlast  = rsp_last_ff;

   // stack fill stays within one group
   a_fill_range : assert property (@(posedge clock) disable iff (reset)
      (fill_ff != '0) && (int'(fill_ff) <= gflba_pkg::GROUP_SIZE))
      else $error("stack fill out of range");

   // an error result always closes its request
   a_err_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != gflba_pkg::STATUS_OK)) |-> rsp_last_ff)
      else $error("error result without last");

   // a finished spill leaves only the freed block on the stack
   a_spill_end : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == gflba_pkg::ST_SPILL) && group_done)
      |=> ((fill_ff == gflba_pkg::FILL_W'(1))
           && (bottom_ff == gflba_pkg::ELEM_W'($past(blk_ff)))))
      else $error("spill did not reset the stack");

   // the stack RAM is never read and written in the same cycle
   a_stk_port : assert property (@(posedge clock) disable iff (reset)
      !(stk_we && stk_re))
      else $error("stack RAM read and write overlap");

endmodule
`default_nettype wire
